[sv/r64a_pkg.sv]
// ----------------------------------------------------------------------------
// r64a_pkg
// Shared types, constants and functions of the radix-64 armor encoder.
// ----------------------------------------------------------------------------
package r64a_pkg;

   localparam logic [23:0] CrcInit = 24'hB704CE;
   localparam logic [23:0] CrcPoly = 24'h864CFB;
   localparam logic [6:0]  NlChar  = 7'h0A;
   localparam logic [6:0]  PadChar = 7'h3D;

   localparam int CmdDepth = 4;
   localparam int CmdPtrW  = $clog2(CmdDepth);
   localparam int CmdCntW  = $clog2(CmdDepth + 1);

   localparam logic [3:0] LastGroupOnLine = 4'd15;

   // one unit of work for the back end
   typedef struct packed {
      logic [23:0] triple;     // three bytes, missing bytes zero
      logic        has_group;  // a full or padded group is emitted
      logic [2:0]  sym_cnt;    // symbols of the group, rest is padding
      logic        line_end;   // newline after the group
      logic        last;       // trailer follows
      logic [23:0] crc;        // checksum so far, of the whole message on the last command
   } cmd_type;

   function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] data);
      logic [23:0] c;
      logic        top;
      c = crc ^ {data, 16'h0000};
      for (int k = 0; k < 8; k++) begin
         top = c[23];
         c   = {c[22:0], 1'b0};
         if (top) begin
            c = c ^ CrcPoly;
         end
      end
      return c;
   endfunction

   function automatic logic [6:0] b64_sym(input logic [5:0] v);
      logic [6:0] ch;
      case (v) inside
         [6'd0:6'd25]:  ch = 7'h41 + {1'b0, v};
         [6'd26:6'd51]: ch = 7'h61 + {1'b0, v} - 7'd26;
         [6'd52:6'd61]: ch = 7'h30 + {1'b0, v} - 7'd52;
         6'd62:         ch = 7'h2B;
         default:       ch = 7'h2F;
      endcase
      return ch;
   endfunction

endpackage

[sv/r64a_front.sv]
// ----------------------------------------------------------------------------
// r64a_front
// Accepts message bytes, updates the checksum, gathers groups of three and
// hands one command per completed group or final byte to the queue.
// ----------------------------------------------------------------------------
module r64a_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             last_byte,
   output logic             cmd_push,
   output r64a_pkg::cmd_type cmd
);
   import r64a_pkg::*;

   logic [23:0] crc_ff, crc_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  groups_ff, groups_in;
   logic [23:0] crc_next;

   assign crc_next = crc_byte(crc_ff, data_byte);

   always_comb begin
      crc_in    = crc_ff;
      held0_in  = held0_ff;
      held1_in  = held1_ff;
      phase_in  = phase_ff;
      groups_in = groups_ff;
      cmd_push  = 1'b0;
      cmd       = '0;
      cmd.crc   = crc_next;
      cmd.last  = last_byte;
      if (accept) begin
         crc_in = crc_next;
         if (phase_ff == 2'd2) begin
            cmd.triple    = {held0_ff, held1_ff, data_byte};
            cmd.has_group = 1'b1;
            cmd.sym_cnt   = 3'd4;
            cmd.line_end  = (groups_ff == LastGroupOnLine);
            cmd_push      = 1'b1;
            phase_in      = 2'd0;
            groups_in     = groups_ff + 4'd1;
         end else begin
            if (phase_ff[0]) begin
               held1_in = data_byte;
            end else begin
               held0_in = data_byte;
            end
            phase_in = phase_ff + 2'd1;
            if (last_byte) begin
               cmd.has_group = 1'b1;
               cmd_push      = 1'b1;
               if (phase_ff[0]) begin
                  cmd.triple  = {held0_ff, data_byte, 8'h00};
                  cmd.sym_cnt = 3'd3;
               end else begin
                  cmd.triple  = {data_byte, 16'h0000};
                  cmd.sym_cnt = 3'd2;
               end
            end
         end
         if (last_byte) begin
            cmd_push  = 1'b1;
            crc_in    = CrcInit;
            held0_in  = 8'h00;
            held1_in  = 8'h00;
            phase_in  = 2'd0;
            groups_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CrcInit;
         held0_ff  <= 8'h00;
         held1_ff  <= 8'h00;
         phase_ff  <= 2'd0;
         groups_ff <= 4'd0;
      end else begin
         crc_ff    <= crc_in;
         held0_ff  <= held0_in;
         held1_ff  <= held1_in;
         phase_ff  <= phase_in;
         groups_ff <= groups_in;
      end
   end

endmodule

[sv/r64a_queue.sv]
// ----------------------------------------------------------------------------
// r64a_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module r64a_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  r64a_pkg::cmd_type push_cmd,
   input  logic              pop,
   output r64a_pkg::cmd_type head_cmd,
   output logic              q_full,
   output logic              q_empty
);
   import r64a_pkg::*;

   cmd_type              slot_ff [CmdDepth];
   logic [CmdPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CmdPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CmdCntW-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_full   = (count_ff == CmdCntW'(CmdDepth));
   assign q_empty  = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !q_full;
   assign do_pop   = pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/r64a_back.sv]
// ----------------------------------------------------------------------------
// r64a_back
// Expands commands into armored characters, one per cycle unless the result
// side stalls, into an output register that the result side drains.
// ----------------------------------------------------------------------------
module r64a_back (
   input  logic              clock,
   input  logic              reset,
   input  r64a_pkg::cmd_type head_cmd,
   input  logic              q_empty,
   output logic              q_pop,
   output logic [6:0]        out_char,
   output logic              last_char,
   output logic              out_empty,
   input  logic              out_pop
);
   import r64a_pkg::*;

   typedef enum logic [3:0] {
      StepGrp0,
      StepGrp1,
      StepGrp2,
      StepGrp3,
      StepLnNl,
      StepTrNl,
      StepTrPad,
      StepCrc0,
      StepCrc1,
      StepCrc2,
      StepCrc3,
      StepEnd
   } step_type;

   cmd_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   step_type   step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;

   logic       advance, done, load;
   step_type   step_next;
   logic [6:0] ch;
   logic [5:0] grp_sext;

   assign advance = busy_ff && (!valid_ff || out_pop);
   assign load    = (!busy_ff || (advance && done)) && !q_empty;
   assign q_pop   = load;

   always_comb begin
      case (step_ff[1:0])
         2'd0:    grp_sext = cur_ff.triple[23:18];
         2'd1:    grp_sext = cur_ff.triple[17:12];
         2'd2:    grp_sext = cur_ff.triple[11:6];
         default: grp_sext = cur_ff.triple[5:0];
      endcase
   end

   always_comb begin
      ch        = NlChar;
      done      = 1'b0;
      step_next = step_type'(step_ff + 4'd1);
      case (step_ff)
         StepGrp0, StepGrp1, StepGrp2, StepGrp3: begin
            ch = ({1'b0, step_ff[1:0]} < cur_ff.sym_cnt) ? b64_sym(grp_sext) : PadChar;
            if (step_ff == StepGrp3) begin
               if (cur_ff.line_end) begin
                  step_next = StepLnNl;
               end else if (cur_ff.last) begin
                  step_next = StepTrNl;
               end else begin
                  done = 1'b1;
               end
            end
         end
         StepLnNl: begin
            ch = NlChar;
            if (!cur_ff.last) begin
               done = 1'b1;
            end
         end
         StepTrNl:  ch = NlChar;
         StepTrPad: ch = PadChar;
         StepCrc0:  ch = b64_sym(cur_ff.crc[23:18]);
         StepCrc1:  ch = b64_sym(cur_ff.crc[17:12]);
         StepCrc2:  ch = b64_sym(cur_ff.crc[11:6]);
         StepCrc3:  ch = b64_sym(cur_ff.crc[5:0]);
         StepEnd: begin
            ch        = NlChar;
            done      = 1'b1;
            step_next = StepGrp0;
         end
         default: begin
            ch        = NlChar;
            done      = 1'b1;
            step_next = StepGrp0;
         end
      endcase
   end

   always_comb begin
      cur_in   = cur_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (valid_ff && out_pop) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in = 1'b1;
         char_in  = ch;
         last_in  = (step_ff == StepEnd);
         step_in  = step_next;
         if (done) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         cur_in  = head_cmd;
         busy_in = 1'b1;
         step_in = head_cmd.has_group ? StepGrp0 : StepTrNl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         busy_ff  <= 1'b0;
         step_ff  <= StepGrp0;
         valid_ff <= 1'b0;
         char_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         cur_ff   <= cur_in;
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
         char_ff  <= char_in;
         last_ff  <= last_in;
      end
   end

   assign out_char  = char_ff;
   assign last_char = last_ff;
   assign out_empty = !valid_ff;

endmodule

[sv/radix64_armor_encoder_crc24_core.sv]
// ----------------------------------------------------------------------------
// radix64_armor_encoder_crc24_core
// Radix-64 armor encoder with a CRC-24 trailer line.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while full is low; the front end updates the
// checksum in the same cycle and queues one command per finished group of
// three bytes or final byte (command queue of four entries). The back end
// writes one character per cycle into the output register unless the output
// side stalls, so the output side sets the sustained rate: four characters
// per three bytes plus one newline per 48 bytes, and the final byte adds its
// group, padded where short, and the checksum line. A message must hold at
// least one byte; once its final byte is taken the front end starts the next
// message from its reset state.
module radix64_armor_encoder_crc24_core (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       push,
   output logic       full,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_char,
   output logic       empty,
   input  logic       pop
);
   import r64a_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head_cmd;
   logic    q_full, q_empty, q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   r64a_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   r64a_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .q_full   (q_full),
      .q_empty  (q_empty)
   );

   r64a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .out_char  (rsp_out_char),
      .last_char (rsp_last_char),
      .out_empty (empty),
      .out_pop   (pop)
   );

endmodule

[sv/r64a_checker.sv]
// ----------------------------------------------------------------------------
// r64a_checker
// Port-level checks of the armor encoder, bound to the top level.
// ----------------------------------------------------------------------------
module r64a_checker (
   input logic       clock,
   input logic       reset,
   input logic       push,
   input logic       full,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_char,
   input logic       empty,
   input logic       pop
);
   import r64a_pkg::*;

   // nothing waits on the result side right after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   // the command queue is drained by reset
   a_reset_not_full : assert property (@(posedge clock) reset |=> !full)
      else $error("input side full after reset");

   // a waiting result holds until taken
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_char) && $stable(rsp_last_char)))
      else $error("waiting result changed");

   // the closing mark sits on a newline
   a_last_nl : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_char) |-> (rsp_out_char == NlChar))
      else $error("closing mark on a character other than newline");

endmodule

bind radix64_armor_encoder_crc24_core r64a_checker u_r64a_checker (
   .clock         (clock),
   .reset         (reset),
   .push          (push),
   .full          (full),
   .rsp_out_char  (rsp_out_char),
   .rsp_last_char (rsp_last_char),
   .empty         (empty),
   .pop           (pop)
);

[tb/radix64_armor_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix64_armor_checker
// Watches the byte and character channels of the radix-64 armor encoder,
// predicts the armored text of every accepted byte (base64 groups, line
// breaks, padding, CRC-24 trailer) and compares each accepted character
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module radix64_armor_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       push,
   input  logic       full,
   input  logic [6:0] rsp_out_char,
   input  logic       rsp_last_char,
   input  logic       empty,
   input  logic       pop,
   output int         errors,
   output int         pending,
   output int         chars_checked
);

   localparam logic [23:0] CrcSeed = 24'hB704CE;
   localparam logic [23:0] CrcTaps = 24'h864CFB;

   typedef struct packed {
      logic [6:0] ch;
      logic       final_nl;
   } armor_char_type;

   logic [23:0]    crc_acc;
   logic [7:0]     held0;
   logic [7:0]     held1;
   logic [1:0]     held_cnt;
   logic [3:0]     line_groups;
   armor_char_type text_q[$];
   int             fail_cnt;
   int             match_cnt;

   assign errors        = fail_cnt;
   assign chars_checked = match_cnt;

   function automatic logic [23:0] crc24_next(input logic [23:0] crc, input logic [7:0] b);
      logic [23:0] c;
      logic        fb;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = c[23] ^ b[k];
         c  = {c[22:0], 1'b0};
         if (fb) begin
            c = c ^ CrcTaps;
         end
      end
      return c;
   endfunction

   function automatic logic [6:0] radix_char(input logic [5:0] v);
      string      abc;
      logic [7:0] code;
      abc  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      code = abc.getc(int'(v));
      return code[6:0];
   endfunction

   task automatic report_mismatch(input string what);
      fail_cnt++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic expect_char(input logic [6:0] ch, input logic fin);
      text_q.push_back('{ch, fin});
   endtask

   // nsym symbols taken from the top of triple, the rest padding
   task automatic emit_group(input logic [23:0] triple, input int nsym);
      for (int i = 0; i < 4; i++) begin
         if (i < nsym) begin
            expect_char(radix_char(triple[23 - 6 * i -: 6]), 1'b0);
         end else begin
            expect_char(r64a_pkg::PadChar, 1'b0);
         end
      end
   endtask

   task automatic clear_message();
      crc_acc     = CrcSeed;
      held0       = '0;
      held1       = '0;
      held_cnt    = '0;
      line_groups = '0;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic lst);
      crc_acc = crc24_next(crc_acc, b);
      if (held_cnt == 2'd2) begin
         emit_group({held0, held1, b}, 4);
         held_cnt    = '0;
         line_groups = line_groups + 4'd1;
         if (line_groups == 4'd0) begin
            expect_char(r64a_pkg::NlChar, 1'b0);
         end
      end else begin
         if (held_cnt == 2'd0) begin
            held0 = b;
         end else begin
            held1 = b;
         end
         held_cnt = held_cnt + 2'd1;
      end
      if (lst) begin
         if (held_cnt == 2'd2) begin
            emit_group({held0, held1, 8'h00}, 3);
         end else if (held_cnt == 2'd1) begin
            emit_group({held0, 16'h0000}, 2);
         end
         // checksum line
         expect_char(r64a_pkg::NlChar, 1'b0);
         expect_char(r64a_pkg::PadChar, 1'b0);
         emit_group(crc_acc, 4);
         expect_char(r64a_pkg::NlChar, 1'b1);
         clear_message();
      end
   endtask

   task automatic check_char();
      armor_char_type want;
      if (text_q.size() == 0) begin
         report_mismatch($sformatf("char 0x%02h last=%0b with nothing expected",
                                   rsp_out_char, rsp_last_char));
      end else begin
         want = text_q.pop_front();
         match_cnt++;
         if (rsp_out_char !== want.ch) begin
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      rsp_out_char, want.ch));
         end
         if (rsp_last_char !== want.final_nl) begin
            report_mismatch($sformatf("last_char %0b, expected %0b",
                                      rsp_last_char, want.final_nl));
         end
      end
   endtask

   initial begin
      fail_cnt  = 0;
      match_cnt = 0;
      pending   = 0;
      clear_message();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         text_q.delete();
         pending <= 0;
      end else begin
         if (pop && !empty) begin
            check_char();
         end
         if (push && !full) begin
            predict_byte(req_data_byte, req_last_byte);
         end
         pending <= text_q.size();
      end
   end

endmodule

[tb/tb_radix64_armor_encoder_crc24_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix64_armor_encoder_crc24_core
// Feeds messages to the radix-64 armor encoder: short directed messages with
// extreme bytes, a 48-byte block, a long output hold-off and random messages
// under three idle mixes. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_radix64_armor_encoder_crc24_core;

   localparam int WatchdogLimit = 4000;
   localparam int HoldCycles    = 400;
   localparam int TailCycles    = 30;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic [7:0] req_data_byte = '0;
   logic       req_last_byte = 1'b0;
   logic       push          = 1'b0;
   logic       full;
   logic [6:0] rsp_out_char;
   logic       rsp_last_char;
   logic       empty;
   logic       pop           = 1'b0;

   logic hold_kick  = 1'b0;
   int   stall_pct  = 0;
   int   idle_pct   = 0;
   int   hold_left  = 0;
   int   quiet_cnt  = 0;
   int   msg_cnt    = 0;
   int   byte_cnt   = 0;
   int   errors;
   int   pending;
   int   chars_checked;

   logic [7:0] dir_bytes [22] = '{
      8'h00,
      8'hFF,
      8'hFF, 8'h00,
      8'h00, 8'hFF, 8'h55,
      8'hFF, 8'hFF, 8'hFF, 8'h00,
      8'h00, 8'h00, 8'h00, 8'hAA, 8'hFF,
      8'h80, 8'h01, 8'h7F, 8'hFE, 8'h12, 8'h34
   };
   int dir_lens [7] = '{1, 1, 2, 3, 4, 5, 6};

   radix64_armor_encoder_crc24_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push          (push),
      .full          (full),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .empty         (empty),
      .pop           (pop)
   );

   radix64_armor_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push          (push),
      .full          (full),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .empty         (empty),
      .pop           (pop),
      .errors        (errors),
      .pending       (pending),
      .chars_checked (chars_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // output side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         pop       <= 1'b0;
         hold_left <= 0;
      end else if (hold_kick) begin
         pop       <= 1'b0;
         hold_left <= HoldCycles;
      end else if (hold_left != 0) begin
         pop       <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         pop <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cnt <= 0;
      end else begin
         quiet_cnt <= quiet_cnt + 1;
         if (quiet_cnt >= WatchdogLimit) begin
            $display("timeout: no item moved for %0d cycles", WatchdogLimit);
            $display("[radix64_armor_encoder_crc24_core] ERROR");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic lst);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      push          <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      byte_cnt++;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic send_random_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
      msg_cnt++;
   endtask

   task automatic send_random_phase(input int n);
      int goal;
      goal = byte_cnt + n;
      while (byte_cnt < goal) begin
         send_random_message($urandom_range(1, 9));
      end
   endtask

   // sender pauses until every predicted char has come out
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int pos;
      pos = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_lens[m]) begin
         for (int i = 0; i < dir_lens[m]; i++) begin
            send_byte(dir_bytes[pos], i == dir_lens[m] - 1);
            pos++;
         end
         msg_cnt++;
      end
      drain();

      // full line of 16 groups right before the checksum line
      send_random_message(48);
      drain();

      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      send_random_message(30);
      drain();

      idle_pct = 82;
      send_random_phase(12);
      drain();

      idle_pct = 0;
      stall_pct <= 82;
      send_random_phase(12);
      drain();

      idle_pct = 29;
      stall_pct <= 29;
      send_random_phase(12);
      drain();

      repeat (TailCycles) @(posedge clock);

      $display("armor run: %0d messages, %0d bytes, %0d characters compared",
               msg_cnt, byte_cnt, chars_checked);
      $display("covered padded and unpadded ends, a 48-byte block, output hold-off, idle mixes");
      if (errors == 0) begin
         $display("[radix64_armor_encoder_crc24_core] OK");
      end else begin
         $display("[radix64_armor_encoder_crc24_core] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/r64a_pkg.sv
sv/r64a_front.sv
sv/r64a_queue.sv
sv/r64a_back.sv
sv/radix64_armor_encoder_crc24_core.sv
sv/r64a_checker.sv
tb/radix64_armor_checker.sv
tb/tb_radix64_armor_encoder_crc24_core.sv
